// ===== hw/rtl/mh3_pkg.sv =====
package mh3_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  typedef enum logic [1:0] {
    KIND_FULL,
    KIND_TAIL,
    KIND_EMPTY,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [31:0] key;
    kind_t       kind;
    logic [2:0]  count;
    logic        last;
  } qent_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int amount);
    rotl = (v << amount) | (v >> (32 - amount));
  endfunction

endpackage

// ===== hw/rtl/murmur3_32_stream_hash_unit.sv =====
// MurmurHash3 x86_32 over a streamed key.
// Input channel s_axis: one little-endian key word per transfer, byte count
// in tdata, tlast on the final word. A short non-last word, or a count over
// four, ends the message with an error result (hash 0, tuser set).
// Output channel m_axis: one result per message, hash in tdata.
// Config channel cfg: one write sets the seed, used from the next message;
// write only while the unit is idle.
// Throughput: one key word per cycle. The front end scrambles the key words
// through two multiplier stages, s1 and s2; the back end accumulator loop
// is combinational around its register; finalization is registered in f0,
// f1, f2 and the output register, which drives m_axis_tvalid. Reset clears the
// valid flags, queue pointers and count, accumulator and length, and the
// seed to 0. When m_axis stalls, the result holds in the output register;
// the finalizer, queue and front end fill until s_axis_tready drops.
module murmur3_32_stream_hash_unit #(
  parameter int QUEUE_DEPTH = mh3_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // hash_value[31:0]
  output logic [0:0]  m_axis_tuser,  // length_error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import mh3_pkg::*;

  logic [31:0] seed;
  qent_t       f_ent;
  logic        f_ent_valid;
  logic        f_ent_ready;
  qent_t       q_ent;
  logic        q_ent_valid;
  logic        q_ent_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  mh3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .data_word  (s_axis_tdata[31:0]),
    .byte_count (s_axis_tdata[34:32]),
    .last_word  (s_axis_tlast),
    .ent_valid  (f_ent_valid),
    .ent_ready  (f_ent_ready),
    .ent        (f_ent)
  );

  mh3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_ent_valid),
    .push_ready (f_ent_ready),
    .push_data  (f_ent),
    .pop_valid  (q_ent_valid),
    .pop_ready  (q_ent_ready),
    .pop_data   (q_ent)
  );

  mh3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .seed         (seed),
    .ent_valid    (q_ent_valid),
    .ent_ready    (q_ent_ready),
    .ent          (q_ent),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .hash_value   (m_axis_tdata),
    .length_error (m_axis_tuser[0])
  );

endmodule

// ===== hw/rtl/mh3_front.sv =====
module mh3_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      data_word,
  input  logic [2:0]       byte_count,
  input  logic             last_word,
  output logic             ent_valid,
  input  logic             ent_ready,
  output mh3_pkg::qent_t   ent
);
  import mh3_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_prod;
  kind_t       s1_kind;
  logic [2:0]  s1_count;
  logic        s1_last;

  logic        s2_valid;
  qent_t       s2_ent;

  logic        adv1;
  logic        adv2;
  kind_t       kind;
  logic [31:0] mask;
  logic [31:0] masked;
  logic [31:0] prod1;
  logic [31:0] prod2;

  assign adv2     = !s2_valid || ent_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_comb begin
    priority if ((!last_word && byte_count != FULL_COUNT) || byte_count > FULL_COUNT) begin
      kind = KIND_ERROR;
    end else if (byte_count == FULL_COUNT) begin
      kind = KIND_FULL;
    end else if (byte_count == 3'd0) begin
      kind = KIND_EMPTY;
    end else begin
      kind = KIND_TAIL;
    end
  end

  always_comb begin
    unique case (byte_count)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign masked = data_word & mask;
  assign prod1  = masked * MIX_C1;
  assign prod2  = rotl(s1_prod, 15) * MIX_C2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_prod  <= prod1;
      s1_kind  <= kind;
      s1_count <= byte_count;
      s1_last  <= last_word;
    end
    if (adv2 && s1_valid) begin
      s2_ent.key   <= prod2;
      s2_ent.kind  <= s1_kind;
      s2_ent.count <= s1_count;
      s2_ent.last  <= s1_last;
    end
  end

  assign ent_valid = s2_valid;
  assign ent       = s2_ent;

endmodule

// ===== hw/rtl/mh3_queue.sv =====
module mh3_queue #(
  parameter int DEPTH = mh3_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mh3_pkg::qent_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mh3_pkg::qent_t pop_data
);
  import mh3_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qent_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != FULL_CNT;
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mh3_back.sv =====
module mh3_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    seed,
  input  logic           ent_valid,
  output logic           ent_ready,
  input  mh3_pkg::qent_t ent,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    hash_value,
  output logic           length_error
);
  import mh3_pkg::*;

  logic        in_msg;
  logic [31:0] acc;
  logic [31:0] len;

  logic        f0_valid;
  logic [31:0] f0_x;
  logic        f0_err;
  logic        f1_valid;
  logic [31:0] f1_y;
  logic        f1_err;
  logic        f2_valid;
  logic [31:0] f2_z;
  logic        f2_err;
  logic        o_valid;
  logic [31:0] o_hash;
  logic        o_err;

  logic        adv0;
  logic        adv1;
  logic        adv2;
  logic        adv_o;
  logic        pop;
  logic        is_err;
  logic        closes;
  logic [31:0] base_h;
  logic [31:0] base_len;
  logic [31:0] rot_h;
  logic [31:0] acc_next;
  logic [31:0] len_next;

  assign adv_o     = !o_valid || out_ready;
  assign adv2      = !f2_valid || adv_o;
  assign adv1      = !f1_valid || adv2;
  assign adv0      = !f0_valid || adv1;
  assign ent_ready = adv0;
  assign pop       = ent_valid && adv0;

  assign is_err   = ent.kind == KIND_ERROR;
  assign closes   = is_err || ent.last;
  assign base_h   = in_msg ? acc : seed;
  assign base_len = in_msg ? len : 32'd0;
  assign rot_h    = rotl(base_h ^ ent.key, 13);
  assign len_next = base_len + {29'd0, ent.count};

  always_comb begin
    unique case (ent.kind)
      KIND_FULL:  acc_next = (rot_h << 2) + rot_h + MIX_ADD;
      KIND_TAIL:  acc_next = base_h ^ ent.key;
      KIND_EMPTY: acc_next = base_h;
      KIND_ERROR: acc_next = base_h;
      default:    acc_next = base_h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg   <= 1'b0;
      acc      <= '0;
      len      <= '0;
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (pop) begin
        in_msg <= !closes;
        acc    <= acc_next;
        len    <= len_next;
      end
      if (adv0) begin
        f0_valid <= pop && closes;
      end
      if (adv1) begin
        f1_valid <= f0_valid;
      end
      if (adv2) begin
        f2_valid <= f1_valid;
      end
      if (adv_o) begin
        o_valid <= f2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && closes) begin
      f0_x   <= acc_next ^ len_next;
      f0_err <= is_err;
    end
    if (adv1 && f0_valid) begin
      f1_y   <= (f0_x ^ (f0_x >> 16)) * FIN_M1;
      f1_err <= f0_err;
    end
    if (adv2 && f1_valid) begin
      f2_z   <= (f1_y ^ (f1_y >> 13)) * FIN_M2;
      f2_err <= f1_err;
    end
    if (adv_o && f2_valid) begin
      o_hash <= f2_err ? 32'd0 : (f2_z ^ (f2_z >> 16));
      o_err  <= f2_err;
    end
  end

  assign out_valid    = o_valid;
  assign hash_value   = o_hash;
  assign length_error = o_err;

endmodule
